### rtl/assert_macros.svh
// assertion macros for the rtl files, used by the converter top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

### rtl/dtfp_pkg.sv
// shared types, constants and a helper function for the decimal text converter
package dtfp_pkg;

	localparam int unsigned VALUE_W = 59;
	localparam int unsigned FRACTION_DIGITS_DEFAULT = 6;

	// largest value that can be reported (2^59 - 1)
	localparam logic [VALUE_W-1:0] SAFE_LIMIT = {VALUE_W{1'b1}};

	// character codes
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_RANGE   = 2'd2;

	// one input transfer
	typedef struct packed {
		logic [7:0] char_code;
		logic       char_present;
		logic       last;
		logic       below_one_check;
	} dtfp_in_t;

	// one result transfer
	typedef struct packed {
		logic [VALUE_W-1:0] fixed_value;
		logic [1:0]         status;
	} dtfp_out_t;

	// per-string parse flags
	typedef struct packed {
		logic content_started;
		logic trailing_space_seen;
		logic point_seen;
		logic whole_overflow;
		logic format_error;
	} dtfp_flags_t;

	// power of ten, for elaboration-time constants
	function automatic logic [63:0] pow10(input int unsigned n);
		logic [63:0] p;
		p = 64'd1;
		for (int unsigned i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

### rtl/dtfp_step.sv
// next-state and result logic for one character of the decimal text
module dtfp_step #(
	parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FRACTION_DIGITS_DEFAULT,
	parameter int unsigned FRAC_W = 20,
	parameter int unsigned CNT_W = 3
) (
	input  dtfp_pkg::dtfp_in_t                    item,
	input  dtfp_pkg::dtfp_flags_t                 flags,
	input  logic [dtfp_pkg::VALUE_W-1:0]          whole_scaled,
	input  logic [FRAC_W-1:0]                     frac_scaled,
	input  logic [CNT_W-1:0]                      frac_count,
	output dtfp_pkg::dtfp_flags_t                 flags_next,
	output logic [dtfp_pkg::VALUE_W-1:0]          whole_scaled_next,
	output logic [FRAC_W-1:0]                     frac_scaled_next,
	output logic [CNT_W-1:0]                      frac_count_next,
	output dtfp_pkg::dtfp_out_t                   result
);
	import dtfp_pkg::*;

	localparam logic [63:0] SCALE64 = pow10(FRACTION_DIGITS);
	localparam logic [VALUE_W-1:0] SCALE = VALUE_W'(SCALE64);
	// largest whole part, already scaled
	localparam logic [VALUE_W-1:0] CAP_SCALED =
		VALUE_W'((64'(SAFE_LIMIT) / SCALE64) * SCALE64);

	logic [FRAC_W-1:0] place [FRACTION_DIGITS];
	logic [FRAC_W-1:0] place_sel;
	logic [3:0]        digit;
	logic              is_space;
	logic              is_digit;
	logic [63:0]       whole_cand;
	logic [VALUE_W:0]  total;

	// weight of each fraction place
	for (genvar i = 0; i < FRACTION_DIGITS; i++) begin : g_place
		assign place[i] = FRAC_W'(pow10(FRACTION_DIGITS - 1 - i));
	end

	always_comb begin
		place_sel = '0;
		for (int unsigned i = 0; i < FRACTION_DIGITS; i++) begin
			if (frac_count == CNT_W'(i)) begin
				place_sel = place[i];
			end
		end
	end

	// character classes
	assign digit    = 4'(item.char_code - CHAR_ZERO);
	assign is_space = (item.char_code == CHAR_SPACE) ||
		((item.char_code >= CHAR_TAB) && (item.char_code <= CHAR_CR));
	assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);

	// whole part times ten plus the new digit, kept scaled
	assign whole_cand = {whole_scaled, 3'b000} + {4'b0000, whole_scaled, 1'b0} +
		64'(digit) * SCALE64;

	// parse one character
	always_comb begin
		flags_next        = flags;
		whole_scaled_next = whole_scaled;
		frac_scaled_next  = frac_scaled;
		frac_count_next   = frac_count;
		if (item.char_present) begin
			if (is_space) begin
				if (flags.content_started) begin
					flags_next.trailing_space_seen = 1'b1;
				end
			end else if (flags.trailing_space_seen) begin
				flags_next.format_error = 1'b1;
			end else if (item.char_code == CHAR_PLUS) begin
				if (flags.content_started) begin
					flags_next.format_error = 1'b1;
				end
				flags_next.content_started = 1'b1;
			end else begin
				flags_next.content_started = 1'b1;
				if (item.char_code == CHAR_POINT) begin
					if (flags.point_seen) begin
						flags_next.format_error = 1'b1;
					end
					flags_next.point_seen = 1'b1;
				end else if (!is_digit || item.char_code == CHAR_MINUS) begin
					flags_next.format_error = 1'b1;
				end else if (flags.point_seen) begin
					if (frac_count < CNT_W'(FRACTION_DIGITS)) begin
						frac_scaled_next = frac_scaled + FRAC_W'(digit) * place_sel;
						frac_count_next  = frac_count + CNT_W'(1);
					end else if (digit != 4'd0) begin
						flags_next.format_error = 1'b1;
					end
				end else if (!flags.whole_overflow) begin
					if (whole_cand > 64'(CAP_SCALED)) begin
						flags_next.whole_overflow = 1'b1;
						whole_scaled_next = CAP_SCALED;
					end else begin
						whole_scaled_next = VALUE_W'(whole_cand);
					end
				end
			end
		end
	end

	// final value and status from the updated state
	assign total = {1'b0, whole_scaled_next} + (VALUE_W + 1)'(frac_scaled_next);

	always_comb begin
		result.fixed_value = '0;
		result.status      = STATUS_OK;
		if (flags_next.format_error || !flags_next.content_started) begin
			result.status = STATUS_INVALID;
		end else if (flags_next.whole_overflow || total > {1'b0, SAFE_LIMIT}) begin
			result.status = STATUS_RANGE;
		end else if (item.below_one_check && total >= {1'b0, SCALE}) begin
			result.status = STATUS_INVALID;
		end else begin
			result.fixed_value = total[VALUE_W-1:0];
		end
	end

endmodule

### rtl/decimal_text_to_fixed_point_unit.sv
// top level of the decimal text to fixed-point converter
// Takes one character per transfer and, on the transfer marked last, returns the value
// times 10^FRACTION_DIGITS with a status. A new character is taken every cycle while the
// input is not stalled; each one sits in an input register while the parse flags and the
// scaled whole and fraction accumulators are updated from it. The result of a string is
// loaded into the output register at the edge where its last character leaves the
// input register. Input stalls only when a finished result is still waiting and the
// next string's last character is already in the input register.
`include "assert_macros.svh"

module decimal_text_to_fixed_point_unit #(
	parameter int unsigned FRACTION_DIGITS = dtfp_pkg::FRACTION_DIGITS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dtfp_pkg::dtfp_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output dtfp_pkg::dtfp_out_t result
);
	import dtfp_pkg::*;

	localparam int unsigned FRAC_W = $clog2(pow10(FRACTION_DIGITS));
	localparam int unsigned CNT_W  = $clog2(FRACTION_DIGITS + 1);

	dtfp_in_t          item_s1;
	logic              valid_s1;
	dtfp_flags_t       flags_q;
	logic [VALUE_W-1:0] whole_q;
	logic [FRAC_W-1:0] frac_q;
	logic [CNT_W-1:0]  count_q;
	dtfp_flags_t       flags_d;
	logic [VALUE_W-1:0] whole_d;
	logic [FRAC_W-1:0] frac_d;
	logic [CNT_W-1:0]  count_d;
	dtfp_out_t         result_d;
	logic              advance;
	logic              finish;

	dtfp_step #(
		.FRACTION_DIGITS(FRACTION_DIGITS),
		.FRAC_W         (FRAC_W),
		.CNT_W          (CNT_W)
	) u_step (
		.item             (item_s1),
		.flags            (flags_q),
		.whole_scaled     (whole_q),
		.frac_scaled      (frac_q),
		.frac_count       (count_q),
		.flags_next       (flags_d),
		.whole_scaled_next(whole_d),
		.frac_scaled_next (frac_d),
		.frac_count_next  (count_d),
		.result           (result_d)
	);

	// the held character moves on unless it would overwrite a waiting result
	assign advance    = valid_s1 && (!item_s1.last || !result_valid || result_ready);
	assign finish     = advance && item_s1.last;
	assign item_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// parse state, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			whole_q <= '0;
			frac_q  <= '0;
			count_q <= '0;
		end else if (finish) begin
			flags_q <= '0;
			whole_q <= '0;
			frac_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			flags_q <= flags_d;
			whole_q <= whole_d;
			frac_q  <= frac_d;
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (finish) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result <= result_d;
		end
	end

	`ASSERT_IMPLIES(a_value_zero_on_error, clk, arst_n,
		result_valid && result.status != STATUS_OK, result.fixed_value == '0)
	`ASSERT_IMPLIES(a_status_known, clk, arst_n, result_valid,
		result.status == STATUS_OK || result.status == STATUS_INVALID ||
		result.status == STATUS_RANGE)
	`ASSERT_NEXT(a_state_cleared, clk, arst_n, finish,
		flags_q == '0 && whole_q == '0 && frac_q == '0 && count_q == '0)
	`ASSERT_NEXT(a_result_after_last, clk, arst_n, finish, result_valid)
	`ASSERT_IMPLIES(a_stall_cause, clk, arst_n, !item_ready,
		valid_s1 && item_s1.last && result_valid && !result_ready)

endmodule
